// ===== rtl/core/dram_least_issue_delay_assert.svh =====
// Assertion macros for the least issue delay RTL.
// Depends on nothing; included inside module bodies.
`ifndef DRAM_LEAST_ISSUE_DELAY_ASSERT_SVH
`define DRAM_LEAST_ISSUE_DELAY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dli_pkg.sv =====
// Package for the DRAM least issue delay block: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dli_pkg;

    // Device geometry
    localparam int BANK_GROUPS      = 2;
    localparam int BURST_LENGTH     = 8;
    localparam int COL_TO_COL_SHORT = 4;

    // Field widths
    localparam int TIMING_W  = 8;
    localparam int BURST_W   = 7;
    localparam int DELAY_W   = 16;
    localparam int CALC_W    = 12;
    localparam int CFG_IDX_W = 3;

    // Request kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_TO_COL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LAT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_REC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_TO_PRE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TO_PRE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_TO_ACT_S  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_TO_COL_L  = 3'd7;

    typedef logic [TIMING_W-1:0] t_timing_val;

    typedef struct packed {
        t_timing_val act_to_col_delay;
        t_timing_val precharge_time;
        t_timing_val write_latency;
        t_timing_val write_recovery;
        t_timing_val act_to_pre_min;
        t_timing_val read_to_pre;
        t_timing_val act_to_act_short;
        t_timing_val col_to_col_long;
    } t_timing;

    typedef struct packed {
        logic               cmd;
        logic [BURST_W-1:0] burst_count;
        logic               is_aligned;
    } t_req;

endpackage
`default_nettype wire

// ===== rtl/core/dli_if.sv =====
// Channel interfaces of the least issue delay block: request, response, config.
// Depends on dli_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dli_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [dli_pkg::BURST_W-1:0]  burst_count;
    logic                         is_aligned;
    modport source (output valid, cmd, burst_count, is_aligned, input ready);
    modport sink   (input valid, cmd, burst_count, is_aligned, output ready);
endinterface

interface dli_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [dli_pkg::DELAY_W-1:0]  delay_cycles;
    modport source (output valid, delay_cycles, input ready);
    modport sink   (input valid, delay_cycles, output ready);
endinterface

interface dli_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dli_pkg::CFG_IDX_W-1:0] index;
    logic [dli_pkg::TIMING_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dram_least_issue_delay.sv =====
// Least issue delay: an accepted request passes the request register, then the response register drives valid.
// Throughput one request per cycle while o_rsp.ready keeps the response register draining; the single
// combinational calculation stage lies between the request register and the response register.
// Reset (synchronous, active low) empties both stages and loads default timings.
// Depends on dli_pkg, dli_if, dli_cfg_regs, dli_calc and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
module dram_least_issue_delay (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dli_req_if.sink   i_req,
    dli_rsp_if.source o_rsp,
    dli_cfg_if.sink   i_cfg
);
    import dli_pkg::*;
    `include "dram_least_issue_delay_assert.svh"

    t_timing            timing;
    t_req               req_word;
    logic [CALC_W-1:0]  calc_delay;
    logic               out_free;
    logic               s1_adv;

    logic               r_s1_valid;
    t_req               r_s1_req;
    logic               r_out_valid;
    logic [CALC_W-1:0]  r_out_delay;

    dli_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_timing (timing)
    );

    dli_calc u_calc (
        .i_req    (r_s1_req),
        .i_timing (timing),
        .o_delay  (calc_delay)
    );

    // Handshake: advance when the response register is free or draining
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || out_free;
    assign req_word    = '{cmd: i_req.cmd, burst_count: i_req.burst_count,
                           is_aligned: i_req.is_aligned};

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.delay_cycles = DELAY_W'(r_out_delay);

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_req <= req_word;
        end
        if (s1_adv) begin
            r_out_delay <= calc_delay;
        end
    end

    `DLI_ASSERT_NXT(a_s1_to_out, i_clk, i_rst_n, s1_adv, r_out_valid,
                    "stage word lost")
    `DLI_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, !i_req.ready,
                    r_s1_valid && r_out_valid, "stall without full pipe")
    `DLI_ASSERT_IMP(a_delay_range, i_clk, i_rst_n, r_out_valid,
                    o_rsp.delay_cycles[DELAY_W-1:CALC_W] == '0, "delay out of range")

endmodule
`default_nettype wire

// ===== rtl/core/dli_cfg_regs.sv =====
// Timing register file written through the configuration channel.
// Depends on dli_pkg and dli_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
module dli_cfg_regs (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    dli_cfg_if.sink       i_cfg,
    output dli_pkg::t_timing o_timing
);
    import dli_pkg::*;

    t_timing r_timing;
    t_timing n_timing;

    // Always able to take a word
    assign i_cfg.ready = 1'b1;
    assign o_timing    = r_timing;

    // Decode the index and replace one field
    always_comb begin
        n_timing = r_timing;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ACT_TO_COL:   n_timing.act_to_col_delay = i_cfg.data;
                CFG_PRECHARGE:    n_timing.precharge_time   = i_cfg.data;
                CFG_WRITE_LAT:    n_timing.write_latency    = i_cfg.data;
                CFG_WRITE_REC:    n_timing.write_recovery   = i_cfg.data;
                CFG_ACT_TO_PRE:   n_timing.act_to_pre_min   = i_cfg.data;
                CFG_READ_TO_PRE:  n_timing.read_to_pre      = i_cfg.data;
                CFG_ACT_TO_ACT_S: n_timing.act_to_act_short = i_cfg.data;
                CFG_COL_TO_COL_L: n_timing.col_to_col_long  = i_cfg.data;
                default:          n_timing = r_timing;
            endcase
        end
    end

    // Hold timings; reset to the default speed bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.act_to_col_delay <= 8'd22;
            r_timing.precharge_time   <= 8'd22;
            r_timing.write_latency    <= 8'd16;
            r_timing.write_recovery   <= 8'd24;
            r_timing.act_to_pre_min   <= 8'd52;
            r_timing.read_to_pre      <= 8'd12;
            r_timing.act_to_act_short <= 8'd9;
            r_timing.col_to_col_long  <= 8'd8;
        end else begin
            r_timing <= n_timing;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dli_calc.sv =====
// Combinational delay calculation for one registered request.
// Depends on dli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dli_calc (
    input  wire dli_pkg::t_req              i_req,
    input  wire dli_pkg::t_timing           i_timing,
    output logic [dli_pkg::CALC_W-1:0]      o_delay
);
    import dli_pkg::*;

    localparam logic [CALC_W-1:0] CCDS     = CALC_W'(COL_TO_COL_SHORT);
    localparam logic [CALC_W-1:0] HALF_BL  = CALC_W'(BURST_LENGTH / 2);
    localparam logic [CALC_W-1:0] PRE_PAD  = CALC_W'(3);

    logic [BURST_W-1:0] b;
    logic [BURST_W-1:0] b_m1;
    logic [BURST_W-1:0] b_m4;
    logic [BURST_W-1:0] b_m5;
    logic [CALC_W-1:0]  rrd;
    logic [CALC_W-1:0]  rcd;
    logic [CALC_W-1:0]  ccdl;
    logic [CALC_W-1:0]  act_cas;
    logic [1:0]         act_lim;
    logic [1:0]         act_n;
    logic [CALC_W-1:0]  spacing;
    logic [CALC_W-1:0]  via_rtp;
    logic [CALC_W-1:0]  via_ras;
    logic [CALC_W-1:0]  base;

    // Treat zero bursts as one
    always_comb begin
        b    = (i_req.burst_count == '0) ? BURST_W'(1) : i_req.burst_count;
        b_m1 = b - BURST_W'(1);
        b_m4 = b - BURST_W'(4);
        b_m5 = b - BURST_W'(5);
        rrd  = CALC_W'(i_timing.act_to_act_short);
        rcd  = CALC_W'(i_timing.act_to_col_delay);
        ccdl = CALC_W'(i_timing.col_to_col_long);
    end

    // Activate to column time
    always_comb begin
        if (BANK_GROUPS > 2) begin
            act_cas = rcd + CALC_W'(b_m1) * CCDS;
        end else if (b <= BURST_W'(4)) begin
            act_cas = rcd + (b_m1[0] ? rrd : '0) + (b_m1[1] ? (rrd << 1) : '0);
        end else if (b <= BURST_W'(6)) begin
            act_cas = (rrd << 1) + rcd + (b_m4[1] ? (ccdl << 1) : ccdl) + CCDS;
        end else if (b <= BURST_W'(8)) begin
            act_cas = (rrd << 1) + rrd + rcd + ccdl + CCDS;
        end else if (b[0]) begin
            act_cas = rrd + rcd + (ccdl << 1) + CALC_W'(b_m4) * CCDS;
        end else begin
            act_cas = (rrd << 1) + rcd + ccdl + CALC_W'(b_m5) * CCDS;
        end
    end

    // Extra activate spacing for reads: min(b - 1, aligned ? 1 : 3) of tRRD_S
    always_comb begin
        act_lim = i_req.is_aligned ? 2'd1 : 2'd3;
        act_n   = (b_m1 < BURST_W'(act_lim)) ? b_m1[1:0] : act_lim;
        spacing = (act_n[0] ? rrd : '0) + (act_n[1] ? (rrd << 1) : '0);
    end

    // Pick the read or write path, then add precharge
    always_comb begin
        via_rtp = act_cas + CALC_W'(i_timing.read_to_pre);
        via_ras = CALC_W'(i_timing.act_to_pre_min) + spacing;
        case (i_req.cmd)
            CMD_WRITE: base = act_cas + CALC_W'(i_timing.write_latency) + HALF_BL
                              + CALC_W'(i_timing.write_recovery);
            CMD_READ:  base = (via_rtp > via_ras) ? via_rtp : via_ras;
            default:   base = via_rtp;
        endcase
        o_delay = base + CALC_W'(i_timing.precharge_time) + PRE_PAD;
    end

endmodule
`default_nettype wire
